// ===== rtl/bps_pkg.sv =====
package bps_pkg;

    // the pattern register pair holds this many bytes
    localparam int REG_BYTES = 16;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [31:0] POS_LIMIT = 32'hFFFF_FFFF;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_PAT_LO  = 2'd0;
    localparam logic [1:0] REG_PAT_HI  = 2'd1;
    localparam logic [1:0] REG_PAT_LEN = 2'd2;
    localparam logic [1:0] REG_BASE    = 2'd3;

    typedef logic [REG_BYTES-1:0][7:0] pattern_t;

    typedef struct packed {
        pattern_t    pattern;
        logic [4:0]  eff_len;
        logic [31:0] offset_adj;
    } cfg_t;

endpackage

// ===== rtl/bps_cell.sv =====
module bps_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  logic              flush,
    input  logic [7:0]        in_byte,
    input  logic              in_valid,
    input  bps_pkg::pattern_t pattern,
    input  logic [4:0]        eff_len,
    output logic [7:0]        out_byte,
    output logic              out_valid,
    output logic              hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;
    logic       valid_next;
    logic       active;
    logic [3:0] pidx;

    // cell 0 always takes the new word; the others lose it on a stream start
    assign byte_next  = in_byte;
    assign valid_next = in_valid && ((IDX == 0) || !flush);

    // this cell faces pattern byte len-1-IDX while IDX < len
    assign active = int'(eff_len) > IDX;
    assign pidx   = 4'(int'(eff_len) - 1 - IDX);
    assign hit    = !active || (valid_next && (byte_next == pattern[pidx]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_next;
        end
    end

    assign out_byte  = byte_reg;
    assign out_valid = valid_reg;

endmodule

// ===== rtl/bps_cfg_regs.sv =====
module bps_cfg_regs #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bps_pkg::ADDR_W-1:0] paddr,
    input  logic [bps_pkg::DATA_W-1:0] pwdata,
    output logic [bps_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output bps_pkg::cfg_t              cfg
);

    localparam int CAP = (PATTERN_MAX < bps_pkg::REG_BYTES) ? PATTERN_MAX
                                                            : bps_pkg::REG_BYTES;

    logic [63:0] pat_lo_reg;
    logic [63:0] pat_hi_reg;
    logic [4:0]  pat_len_reg;
    logic [31:0] base_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;
    logic [4:0]  eff_len;

    assign reg_idx = paddr[4:3];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= 5'd1;
            base_reg    <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                bps_pkg::REG_PAT_LO:  pat_lo_reg  <= pwdata;
                bps_pkg::REG_PAT_HI:  pat_hi_reg  <= pwdata;
                bps_pkg::REG_PAT_LEN: pat_len_reg <= pwdata[4:0];
                bps_pkg::REG_BASE:    base_reg    <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            bps_pkg::REG_PAT_LO:  prdata = pat_lo_reg;
            bps_pkg::REG_PAT_HI:  prdata = pat_hi_reg;
            bps_pkg::REG_PAT_LEN: prdata = {59'd0, pat_len_reg};
            bps_pkg::REG_BASE:    prdata = {32'd0, base_reg};
            default:              prdata = '0;
        endcase
    end

    // zero length acts as one, long lengths clip to the smaller of the window and the pattern registers
    always_comb
    begin
        if (pat_len_reg == 5'd0)
        begin
            eff_len = 5'd1;
        end
        else if (int'(pat_len_reg) > CAP)
        begin
            eff_len = 5'(CAP);
        end
        else
        begin
            eff_len = pat_len_reg;
        end
    end

    assign cfg.pattern    = {pat_hi_reg, pat_lo_reg};
    assign cfg.eff_len    = eff_len;
    assign cfg.offset_adj = base_reg - {27'd0, eff_len} + 32'd1;

endmodule

// ===== rtl/byte_pattern_search_unit.sv =====
// a match offset is registered and appears on the output in the cycle after its byte is accepted
// throughput: one byte per cycle while in_stall is low, with a combinational compare across the cell row
// the output register frees the input as soon as the held word is taken
// reset: async active low; clears stream position, window valid bits, output valid
// and the configuration registers (pattern zero, length one, base zero)
module byte_pattern_search_unit #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // byte stream in
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       stream_start,
    // match offsets out
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [31:0]                match_offset,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bps_pkg::ADDR_W-1:0] paddr,
    input  logic [bps_pkg::DATA_W-1:0] pwdata,
    output logic [bps_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    bps_pkg::cfg_t cfg;

    // chain wiring: entry k is what cell k hands to cell k+1
    logic [7:0]             byte_chain  [PATTERN_MAX];
    logic                   valid_chain [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hit_vec;

    logic        accept;
    logic [31:0] pos_reg;
    logic [31:0] pos_next;
    logic [31:0] pos_cur;
    logic        exhausted;
    logic        match;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] offset_reg;

    bps_cfg_regs #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a new word may enter whenever the output register is empty or being drained
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // row of window cells: cell 0 holds the newest byte, each cell shifts to the
    // next one on every accepted word and checks the byte it is about to take against the pattern
    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                bps_cell #(
                    .IDX (k)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift_en  (accept),
                    .flush     (stream_start),
                    .in_byte   (data_byte),
                    .in_valid  (1'b1),
                    .pattern   (cfg.pattern),
                    .eff_len   (cfg.eff_len),
                    .out_byte  (byte_chain[k]),
                    .out_valid (valid_chain[k]),
                    .hit       (hit_vec[k])
                );
            end
            else
            begin : g_body
                bps_cell #(
                    .IDX (k)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift_en  (accept),
                    .flush     (stream_start),
                    .in_byte   (byte_chain[k-1]),
                    .in_valid  (valid_chain[k-1]),
                    .pattern   (cfg.pattern),
                    .eff_len   (cfg.eff_len),
                    .out_byte  (byte_chain[k]),
                    .out_valid (valid_chain[k]),
                    .hit       (hit_vec[k])
                );
            end
        end
    endgenerate

    // stream position of the incoming word, saturating at the top
    assign pos_cur   = stream_start ? 32'd0 : pos_reg;
    assign exhausted = (pos_cur == bps_pkg::POS_LIMIT);
    assign pos_next  = exhausted ? pos_cur : pos_cur + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    // every active cell agrees, and the position still counts
    assign match = (&hit_vec) && !exhausted;

    // output register: loaded on accept, emptied when taken downstream
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = match;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // offset_adj already folds in base and the pattern length
    always_ff @(posedge clk)
    begin
        if (accept && match)
        begin
            offset_reg <= cfg.offset_adj + pos_cur;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_offset = offset_reg;

endmodule

// ===== rtl/bps_checker.sv =====
module bps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] match_offset
);

    // a held word keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(match_offset))
        else $error("match word changed while stalled");

    // the input backs up only behind a held output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // a fresh output word needs a byte accepted the cycle before
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && !in_stall) && !(out_valid && out_stall) |=> !out_valid)
        else $error("output word without an accepted byte");

endmodule

bind byte_pattern_search_unit bps_checker u_bps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .match_offset (match_offset)
);
